FILE: design/mtem_pkg.sv
// Shared types, widths and constants for the multi-tap echo mixer.
// No dependencies; the datapath, controller, top level and checker import this package.
`default_nettype none

package mtem_pkg;

  // default sizes, handed to the top level parameters
  localparam int HISTORY_DEPTH_DEF = 32768;
  localparam int MAX_TAPS_DEF      = 16;

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int SPACING_W  = 16;
  localparam int COUNT_W    = 5;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // wet saturation bounds
  localparam int WET_MAX = 32'sh007f_ffff;
  localparam int WET_MIN = -32'sh0080_0000;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_SPACING = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_ALT     = 2'd2;
  localparam logic [1:0] REG_LINEAR  = 2'd3;

  typedef struct packed {
    logic [SPACING_W-1:0] tap_spacing;
    logic [COUNT_W-1:0]   tap_count;
    logic                 alternate_sign;
    logic                 linear_divisor;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted word, clear the sum
    logic rd;         // issue the history read for the current tap
    logic acc_shift;  // add the power-of-two term
    logic div_start;  // start the serial divider on the current tap
    logic acc_div;    // add the divider quotient
    logic step;       // advance to the next tap
    logic finish;     // load the result, store the dry word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic zero_taps;
    logic last_tap;
    logic lin_mode;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/mtem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mtem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/mtem_div.sv
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing; used by the mtem datapath for the linear tap divisor.
`default_nettype none

module mtem_div #(
  parameter int MAG_W = 24,
  parameter int DIV_W = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start_i,
  input  wire logic signed [MAG_W:0] dividend_i,
  input  wire logic [DIV_W-1:0]   divisor_i,
  output logic signed [MAG_W:0]   quot_o,
  output logic                    done_o
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r;
  logic [MAG_W-1:0]   quo_r;
  logic [DIV_W-1:0]   rem_r;

  logic [MAG_W-1:0]   mag;
  logic [DIV_W:0]     rem_sh;
  logic [DIV_W:0]     rem_sub;
  logic               ge;

  // magnitude of the dividend and one restoring step
  always_comb begin
    mag     = dividend_i[MAG_W] ? MAG_W'(-dividend_i) : MAG_W'(dividend_i);
    rem_sh  = {rem_r, quo_r[MAG_W-1]};
    ge      = (rem_sh >= {1'b0, divisor_i});
    rem_sub = rem_sh - {1'b0, divisor_i};
  end

  assign done_o = busy_r && (cnt_r == '0);
  assign quot_o = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  // control
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(MAG_W);
    end else if (done_o) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= dividend_i[MAG_W];
      quo_r <= mag;
      rem_r <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      quo_r <= {quo_r[MAG_W-2:0], ge};
      rem_r <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/mtem_datapath.sv
// Datapath of the echo mixer: history memory, tap address, term, sum, mix.
// Depends on mtem_pkg, mtem_ram and mtem_div.
`default_nettype none

module mtem_datapath import mtem_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int MAX_TAPS      = MAX_TAPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cfg_t                       cfg_i,
  input  wire logic signed [SAMPLE_W-1:0] dry_i,
  input  wire cmd_t                       cmd_i,
  output sts_t                            sts_o,
  output logic signed [SAMPLE_W-1:0]      mixed_o,
  output logic signed [SAMPLE_W-1:0]      wet_o
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int KW     = $clog2(MAX_TAPS + 1);
  localparam int DVW    = $clog2(MAX_TAPS + 2);
  localparam int DLY_W  = SPACING_W + KW;
  localparam int CMP_W  = ((DLY_W > FILL_W) ? DLY_W : FILL_W) + 1;
  localparam int X_W    = SAMPLE_W + 1;
  localparam int SH_W   = X_W + 1;
  localparam int SHA_W  = $clog2(X_W);
  localparam int SUM_W  = X_W + $clog2(MAX_TAPS) + 1;

  logic signed [SAMPLE_W-1:0] dry_r;
  logic [KW-1:0]              taps_r;
  logic [KW-1:0]              k_r;
  logic [DLY_W-1:0]           delay_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [AW-1:0]              wp_r, wp_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic                       src_dry_r;
  logic                       src_zero_r;
  logic signed [SAMPLE_W-1:0] mixed_r;
  logic signed [SAMPLE_W-1:0] wet_r;

  logic [KW-1:0]              taps_eff;
  logic [CMP_W-1:0]           dly_ext, fill_ext, addr_sum;
  logic [AW-1:0]              rd_addr;
  logic                       tap_dry, tap_zero;
  logic [SAMPLE_W-1:0]        rd_data;
  logic signed [X_W-1:0]      x_raw, x_tap;
  logic                       neg;
  logic [SHA_W-1:0]           sh_amt;
  logic signed [SH_W-1:0]     sh_in, sh_bias, sh_out;
  logic signed [X_W-1:0]      sh_term;
  logic signed [X_W-1:0]      div_q;
  logic                       div_done;
  logic [DVW-1:0]             divisor;
  logic signed [SAMPLE_W-1:0] wet_sat;
  logic signed [SAMPLE_W:0]   mix_sum, mix_adj;

  // tap count clamped to the tap limit
  always_comb begin
    if (32'(cfg_i.tap_count) > MAX_TAPS) begin
      taps_eff = KW'(MAX_TAPS);
    end else begin
      taps_eff = KW'(cfg_i.tap_count);
    end
  end

  // history address of the current tap; fill count marks unwritten entries
  always_comb begin
    dly_ext  = CMP_W'(delay_r);
    fill_ext = CMP_W'(fill_r);
    addr_sum = CMP_W'(wp_r) + CMP_W'(HISTORY_DEPTH) - dly_ext;
    if (addr_sum >= CMP_W'(HISTORY_DEPTH)) begin
      rd_addr = AW'(addr_sum - CMP_W'(HISTORY_DEPTH));
    end else begin
      rd_addr = AW'(addr_sum);
    end
    tap_dry  = (delay_r == '0);
    tap_zero = !tap_dry && (dly_ext > fill_ext);
  end

  mtem_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd_i.finish),
    .waddr (wp_r),
    .wdata (dry_r),
    .re    (cmd_i.rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // tap value with optional negation of odd taps
  always_comb begin
    if (src_zero_r) begin
      x_raw = '0;
    end else if (src_dry_r) begin
      x_raw = {dry_r[SAMPLE_W-1], dry_r};
    end else begin
      x_raw = {rd_data[SAMPLE_W-1], rd_data};
    end
    neg   = cfg_i.alternate_sign && k_r[0];
    x_tap = neg ? -x_raw : x_raw;
  end

  // power-of-two term, biased so the shift truncates toward zero
  always_comb begin
    sh_amt  = SHA_W'(k_r);
    sh_in   = {x_tap[X_W-1], x_tap};
    sh_bias = x_tap[X_W-1] ? ((SH_W'(1) << sh_amt) - SH_W'(1)) : '0;
    sh_out  = (sh_in + sh_bias) >>> sh_amt;
    if (32'(k_r) >= X_W) begin
      sh_term = '0;
    end else begin
      sh_term = X_W'(sh_out);
    end
  end

  // linear term by k+1 through the serial divider
  assign divisor = DVW'(k_r) + DVW'(1);

  mtem_div #(
    .MAG_W (SAMPLE_W),
    .DIV_W (DVW)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_start),
    .dividend_i (x_tap),
    .divisor_i  (divisor),
    .quot_o     (div_q),
    .done_o     (div_done)
  );

  // wet saturation and the halved mix
  always_comb begin
    if (sum_r > SUM_W'(WET_MAX)) begin
      wet_sat = SAMPLE_W'(WET_MAX);
    end else if (sum_r < SUM_W'(WET_MIN)) begin
      wet_sat = SAMPLE_W'(WET_MIN);
    end else begin
      wet_sat = sum_r[SAMPLE_W-1:0];
    end
    mix_sum = {dry_r[SAMPLE_W-1], dry_r} + {wet_sat[SAMPLE_W-1], wet_sat};
    mix_adj = mix_sum + {{SAMPLE_W{1'b0}}, mix_sum[SAMPLE_W]};
  end

  // tap walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      taps_r <= '0;
    end else if (cmd_i.load) begin
      k_r    <= KW'(1);
      taps_r <= taps_eff;
    end else if (cmd_i.step) begin
      k_r    <= k_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      dry_r   <= dry_i;
      delay_r <= DLY_W'(cfg_i.tap_spacing);
      sum_r   <= '0;
    end else begin
      if (cmd_i.step) begin
        delay_r <= delay_r + DLY_W'(cfg_i.tap_spacing);
      end
      if (cmd_i.acc_shift) begin
        sum_r <= sum_r + SUM_W'(sh_term);
      end else if (cmd_i.acc_div) begin
        sum_r <= sum_r + SUM_W'(div_q);
      end
    end
    if (cmd_i.rd) begin
      src_dry_r  <= tap_dry;
      src_zero_r <= tap_zero;
    end
    if (cmd_i.finish) begin
      mixed_r <= mix_adj[SAMPLE_W:1];
      wet_r   <= wet_sat;
    end
  end

  // write position and fill count
  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (cmd_i.finish) begin
      wp_nxt = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (fill_r < FILL_W'(HISTORY_DEPTH)) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  // status to the controller
  always_comb begin
    sts_o.zero_taps = (cfg_i.tap_count == '0);
    sts_o.last_tap  = (k_r == taps_r);
    sts_o.lin_mode  = cfg_i.linear_divisor;
    sts_o.div_done  = div_done;
  end

  assign mixed_o = mixed_r;
  assign wet_o   = wet_r;

endmodule

`default_nettype wire

FILE: design/mtem_ctrl.sv
// Controller of the echo mixer: sequences the taps and holds the result handshake.
// Depends on mtem_pkg.
`default_nettype none

module mtem_ctrl import mtem_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_DATA = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = sts_i.zero_taps ? S_FIN : S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.rd  = 1'b1;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        if (sts_i.lin_mode) begin
          cmd_o.div_start = 1'b1;
          state_nxt       = S_DIV;
        end else begin
          cmd_o.acc_shift = 1'b1;
          if (sts_i.last_tap) begin
            state_nxt = S_FIN;
          end else begin
            cmd_o.step = 1'b1;
            state_nxt  = S_ADDR;
          end
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.acc_div = 1'b1;
          if (sts_i.last_tap) begin
            state_nxt = S_FIN;
          end else begin
            cmd_o.step = 1'b1;
            state_nxt  = S_ADDR;
          end
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_o.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/multi_tap_echo_mixer_unit.sv
// Top level of the multi-tap echo mixer: configuration registers and APB port.
// Depends on mtem_pkg, mtem_ctrl and mtem_datapath.
//
// Takes one signed 24-bit word per item and returns one word holding the
// saturated wet echo sum and the halved dry/wet mix. Items are worked one at a
// time. The taps are walked one by one through the single history read port,
// and with the linear divisor each tap also waits on the one-bit-a-cycle
// divider. Unwritten history reads as zero through a fill count, so no
// clearing pass runs after reset. Configuration registers sit at byte
// addresses 0, 4, 8 and 12; the user must write them only while the block
// is idle, as the block itself does not enforce this.
`default_nettype none

module multi_tap_echo_mixer_unit import mtem_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int MAX_TAPS      = MAX_TAPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_dry_sample,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      out_mixed_sample,
  output logic signed [SAMPLE_W-1:0]      out_wet_sample,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]      cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  cfg_t       cfg_r, cfg_nxt;
  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SPACING: cfg_nxt.tap_spacing    = cfg_pwdata[SPACING_W-1:0];
        REG_COUNT:   cfg_nxt.tap_count      = cfg_pwdata[COUNT_W-1:0];
        REG_ALT:     cfg_nxt.alternate_sign = cfg_pwdata[0];
        REG_LINEAR:  cfg_nxt.linear_divisor = cfg_pwdata[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_spacing    <= '0;
      cfg_r.tap_count      <= COUNT_W'(1);
      cfg_r.alternate_sign <= 1'b0;
      cfg_r.linear_divisor <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read mux
  always_comb begin
    unique case (cfg_idx)
      REG_SPACING: cfg_prdata = CFG_DATA_W'(cfg_r.tap_spacing);
      REG_COUNT:   cfg_prdata = CFG_DATA_W'(cfg_r.tap_count);
      REG_ALT:     cfg_prdata = CFG_DATA_W'(cfg_r.alternate_sign);
      REG_LINEAR:  cfg_prdata = CFG_DATA_W'(cfg_r.linear_divisor);
      default:     cfg_prdata = '0;
    endcase
  end

  mtem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mtem_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_TAPS      (MAX_TAPS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg_r),
    .dry_i   (in_dry_sample),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .mixed_o (out_mixed_sample),
    .wet_o   (out_wet_sample)
  );

endmodule

`default_nettype wire

FILE: design/mtem_checker.sv
// Port-level checks for the echo mixer, bound to the top level.
// Depends on mtem_pkg and on the port list of multi_tap_echo_mixer_unit.
`default_nettype none

module mtem_checker import mtem_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic signed [SAMPLE_W-1:0] out_mixed_sample,
  input wire logic signed [SAMPLE_W-1:0] out_wet_sample,
  input wire logic                       cfg_psel,
  input wire logic                       cfg_penable,
  input wire logic                       cfg_pwrite,
  input wire logic [CFG_ADDR_W-1:0]      cfg_paddr,
  input wire logic [CFG_DATA_W-1:0]      cfg_pwdata,
  input wire logic [CFG_DATA_W-1:0]      cfg_prdata,
  input wire logic                       cfg_pready
);

  logic       in_acc, out_acc, cfg_wr;
  logic [2:0] pending_r, pending_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // words accepted but not yet delivered
  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) begin
      pending_nxt = pending_r + 3'd1;
    end else if (!in_acc && out_acc) begin
      pending_nxt = pending_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mixed_sample)
      && $stable(out_wet_sample))
    else $error("stalled result word changed");

  // every result belongs to an accepted word
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pending_r != 3'd0)
    else $error("result word without an accepted input word");

  // at most one word in work and one waiting at the output
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd2)
    else $error("more words in flight than the block can hold");

  // a word is worked alone: input stalls right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken again while a word is in work");

  // tap count reads back what was written
  a_count_rb: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_paddr[3:2] == REG_COUNT) |=>
      (cfg_paddr[3:2] != REG_COUNT) ||
      (cfg_prdata[COUNT_W-1:0] == $past(cfg_pwdata[COUNT_W-1:0])))
    else $error("tap count register read back differs from write");

endmodule

bind multi_tap_echo_mixer_unit mtem_checker u_mtem_checker (.*);

`default_nettype wire

FILE: verif/multi_tap_echo_mixer_unit_test.sv
// Self-checking bench for multi_tap_echo_mixer_unit: directed table, then random words.
// Depends on mtem_pkg and the design top level; predicts every result in place.
`timescale 1ns / 100ps

module multi_tap_echo_mixer_unit_test;
  import mtem_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 72;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mix;
    logic [SAMPLE_W-1:0] wet;
  } echo_word_t;

  typedef struct packed {
    logic [SPACING_W-1:0] spacing;
    logic [COUNT_W-1:0]   taps;
    logic                 alt;
    logic                 lin;
    logic [SAMPLE_W-1:0]  dry;
    logic                 typed;
    logic [SAMPLE_W-1:0]  mix;
    logic [SAMPLE_W-1:0]  wet;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_dry_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_mixed_sample;
  logic signed [SAMPLE_W-1:0] out_wet_sample;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [CFG_ADDR_W-1:0]      cfg_paddr;
  logic [CFG_DATA_W-1:0]      cfg_pwdata;
  logic [CFG_DATA_W-1:0]      cfg_prdata;
  logic                       cfg_pready;

  // predictor state: delay line and register mirror
  logic signed [SAMPLE_W-1:0] echo_line [HISTORY_DEPTH_DEF];
  int                         echo_wr_ptr;
  logic [SPACING_W-1:0]       tap_gap;
  logic [COUNT_W-1:0]         tap_num;
  logic                       flip_odd;
  logic                       lin_div;

  echo_word_t pending_echo [$];
  dir_row_t   dir_table [$];

  int  words_sent;
  int  words_checked;
  int  bad_fields;
  int  settings_used;
  int  quiet_cycles;
  int  stall_run;
  bit  quiet_send;
  bit  quiet_recv;

  multi_tap_echo_mixer_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dry_sample    (in_dry_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mixed_sample (out_mixed_sample),
    .out_wet_sample   (out_wet_sample),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 40);
    return $urandom_range(100, 500);
  endfunction

  // dry word: extremes, small values near zero, full range
  function automatic logic [SAMPLE_W-1:0] pick_dry();
    case ($urandom_range(0, 19))
      0:       return 24'h7fffff;
      1:       return 24'h800000;
      2:       return 24'($urandom_range(0, 15));
      3:       return 24'(0 - $urandom_range(1, 16));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic clear_echo_state();
    for (int i = 0; i < HISTORY_DEPTH_DEF; i++) echo_line[i] = '0;
    echo_wr_ptr = 0;
    tap_gap     = '0;
    tap_num     = 5'd1;
    flip_odd    = 1'b0;
    lin_div     = 1'b0;
  endtask

  // weighted tap sum, saturation, dry/wet average, then history write
  task automatic predict_echo(input logic signed [SAMPLE_W-1:0] dry, output echo_word_t res);
    longint sum;
    longint x;
    longint delay;
    longint wet;
    longint mix;
    int     taps;
    sum  = 0;
    taps = (tap_num > MAX_TAPS_DEF) ? MAX_TAPS_DEF : int'(tap_num);
    for (int k = 1; k <= taps; k++) begin
      delay = longint'(k) * longint'(tap_gap);
      if (delay == 0) x = dry;
      else if (delay > HISTORY_DEPTH_DEF) x = 0;
      else x = echo_line[(echo_wr_ptr + HISTORY_DEPTH_DEF - delay) % HISTORY_DEPTH_DEF];
      if (flip_odd && (k % 2 == 1)) x = -x;
      if (lin_div) sum += x / longint'(k + 1);
      else sum += x / (longint'(1) << k);
    end
    if (sum > WET_MAX) wet = WET_MAX;
    else if (sum < WET_MIN) wet = WET_MIN;
    else wet = sum;
    mix = (longint'(dry) + wet) / 2;
    res.mix = mix[SAMPLE_W-1:0];
    res.wet = wet[SAMPLE_W-1:0];
    echo_line[echo_wr_ptr] = dry;
    echo_wr_ptr = (echo_wr_ptr + 1) % HISTORY_DEPTH_DEF;
  endtask

  task automatic note_bad(input string what, input logic [SAMPLE_W-1:0] want,
                          input logic [SAMPLE_W-1:0] got);
    bad_fields++;
    if (bad_fields <= 10)
      $display("word %0d %s: expected %0d, got %0d", words_checked, what,
               $signed(want), $signed(got));
  endtask

  // one word on the input channel; typed rows replace the predicted result
  task automatic send_word(input logic [SAMPLE_W-1:0] dry, input logic typed,
                           input logic [SAMPLE_W-1:0] mix_typed,
                           input logic [SAMPLE_W-1:0] wet_typed);
    echo_word_t res;
    int         gap;
    gap = pick_gap(quiet_send);
    repeat (gap) begin
      in_valid      = 1'b0;
      in_dry_sample = 24'($urandom);
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_dry_sample = dry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_echo(dry, res);
    if (typed) begin
      res.mix = mix_typed;
      res.wet = wet_typed;
    end
    pending_echo.push_back(res);
    words_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every result is back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_echo.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb write: setup, access; junk above the register width must be dropped
  task automatic set_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] word;
    word = val;
    case (idx)
      REG_SPACING: word[31:16] = 16'($urandom);
      REG_COUNT:   word[31:5]  = 27'($urandom);
      default:     word[31:1]  = 31'($urandom);
    endcase
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = word;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_SPACING: tap_gap  = word[SPACING_W-1:0];
      REG_COUNT:   tap_num  = word[COUNT_W-1:0];
      REG_ALT:     flip_odd = word[0];
      REG_LINEAR:  lin_div  = word[0];
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic apply_setting(input logic [SPACING_W-1:0] spacing,
                               input logic [COUNT_W-1:0] taps,
                               input logic alt, input logic lin);
    wait_drained();
    set_reg(REG_SPACING, 32'(spacing));
    set_reg(REG_COUNT, 32'(taps));
    set_reg(REG_ALT, 32'(alt));
    set_reg(REG_LINEAR, 32'(lin));
    settings_used++;
  endtask

  task automatic add_row(input logic [SPACING_W-1:0] spacing, input logic [COUNT_W-1:0] taps,
                         input logic alt, input logic lin, input logic [SAMPLE_W-1:0] dry,
                         input logic typed, input logic [SAMPLE_W-1:0] mix,
                         input logic [SAMPLE_W-1:0] wet);
    dir_row_t row;
    row = '{spacing: spacing, taps: taps, alt: alt, lin: lin, dry: dry,
            typed: typed, mix: mix, wet: wet};
    dir_table.push_back(row);
  endtask

  // result checker against the oldest expectation
  always @(posedge clk) begin : rx_check
    echo_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_echo.size() == 0) begin
        note_bad("result with nothing pending", '0, out_mixed_sample);
      end else begin
        want = pending_echo.pop_front();
        if (want.mix !== out_mixed_sample) note_bad("mixed_sample", want.mix, out_mixed_sample);
        if (want.wet !== out_wet_sample) note_bad("wet_sample", want.wet, out_wet_sample);
      end
      words_checked++;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n || quiet_recv) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_run <= pick_gap(1'b0);
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dir_row_t              row;
    int                    dir_words;
    int                    drain_at;
    logic [SPACING_W-1:0]  spacing;
    logic [COUNT_W-1:0]    taps;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_dry_sample = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    quiet_send    = 1'b0;
    quiet_recv    = 1'b0;
    words_sent    = 0;
    words_checked = 0;
    bad_fields    = 0;
    settings_used = 0;
    clear_echo_state();

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset setting: one tap at zero spacing, halved dry
    add_row(16'd0, 5'd1, 1'b0, 1'b0, 24'd0, 1'b1, 24'd0, 24'd0);
    add_row(16'd0, 5'd1, 1'b0, 1'b0, 24'h7fffff, 1'b1, 24'd6291455, 24'd4194303);
    add_row(16'd0, 5'd1, 1'b0, 1'b0, 24'h800000, 1'b1, -24'sd6291456, -24'sd4194304);
    add_row(16'd0, 5'd1, 1'b0, 1'b0, -24'sd1, 1'b1, 24'd0, 24'd0);
    add_row(16'd0, 5'd1, 1'b0, 1'b0, -24'sd3, 1'b1, -24'sd2, -24'sd1);
    // no taps: wet is zero
    add_row(16'd0, 5'd0, 1'b0, 1'b0, 24'h7fffff, 1'b1, 24'd4194303, 24'd0);
    add_row(16'd0, 5'd0, 1'b0, 1'b0, 24'h800000, 1'b1, -24'sd4194304, 24'd0);
    add_row(16'd0, 5'd0, 1'b0, 1'b0, -24'sd7, 1'b1, -24'sd3, 24'd0);
    // linear weights on sixteen copies of the dry word saturate both ways
    add_row(16'd0, 5'd16, 1'b0, 1'b1, 24'h7fffff, 1'b1, 24'h7fffff, 24'h7fffff);
    add_row(16'd0, 5'd16, 1'b0, 1'b1, 24'h800000, 1'b1, 24'h800000, 24'h800000);
    // alternating sign at zero spacing
    add_row(16'd0, 5'd16, 1'b1, 1'b0, 24'h7fffff, 1'b0, '0, '0);
    add_row(16'd0, 5'd16, 1'b1, 1'b0, 24'h800000, 1'b0, '0, '0);
    add_row(16'd0, 5'd16, 1'b1, 1'b0, 24'd12345, 1'b0, '0, '0);
    // tap count above the maximum is clamped
    add_row(16'd0, 5'd31, 1'b1, 1'b1, 24'h7fffff, 1'b0, '0, '0);
    add_row(16'd0, 5'd31, 1'b1, 1'b1, 24'h800000, 1'b0, '0, '0);
    // every tap lies beyond the history
    add_row(16'hffff, 5'd16, 1'b0, 1'b0, 24'd5, 1'b1, 24'd2, 24'd0);
    add_row(16'hffff, 5'd16, 1'b0, 1'b0, 24'h800000, 1'b1, -24'sd4194304, 24'd0);
    // short spacing reads back real history
    add_row(16'd1, 5'd4, 1'b1, 1'b0, 24'd100, 1'b0, '0, '0);
    add_row(16'd1, 5'd4, 1'b1, 1'b0, -24'sd200, 1'b0, '0, '0);
    add_row(16'd1, 5'd4, 1'b1, 1'b0, 24'h7fffff, 1'b0, '0, '0);
    add_row(16'd1, 5'd4, 1'b1, 1'b0, 24'h800000, 1'b0, '0, '0);
    add_row(16'd1, 5'd4, 1'b1, 1'b0, 24'd7, 1'b0, '0, '0);
    add_row(16'd3, 5'd16, 1'b0, 1'b1, 24'h7fffff, 1'b0, '0, '0);
    add_row(16'd3, 5'd16, 1'b0, 1'b1, 24'h7fffff, 1'b0, '0, '0);
    add_row(16'd3, 5'd16, 1'b0, 1'b1, 24'h7fffff, 1'b0, '0, '0);

    // directed table
    foreach (dir_table[i]) begin
      row = dir_table[i];
      if ({row.spacing, row.taps, row.alt, row.lin} != {tap_gap, tap_num, flip_odd, lin_div})
        apply_setting(row.spacing, row.taps, row.alt, row.lin);
      send_word(row.dry, row.typed, row.mix, row.wet);
    end
    dir_words = words_sent;

    // random phases, each under its own setting
    for (int p = 0; p < PHASES; p++) begin
      quiet_send = (p % 4 == 1);
      quiet_recv = (p % 4 == 1) || (p % 4 == 2);
      case ($urandom_range(0, 9))
        0:       spacing = '0;
        1:       spacing = 16'($urandom);
        2:       spacing = 16'd32768;
        default: spacing = 16'($urandom_range(1, 37));
      endcase
      taps = $urandom_range(0, 1) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(8, 16));
      if (p == 0) apply_setting(16'd1, 5'd16, 1'b1, 1'b1);
      else if (p == 1) apply_setting(16'd2, 5'd31, 1'b0, 1'b0);
      else apply_setting(spacing, taps, 1'($urandom), 1'($urandom));
      drain_at = $urandom_range(10, 60);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == drain_at) wait_drained();
        send_word(pick_dry(), 1'b0, '0, '0);
      end
    end

    // wind down
    quiet_recv = 1'b0;
    wait_drained();
    repeat (450) @(posedge clk);
    if (pending_echo.size() != 0) begin
      bad_fields += pending_echo.size();
      $display("%0d results never arrived", pending_echo.size());
    end

    $display("covered %0d table words and %0d random words under %0d register settings",
             dir_words, words_sent - dir_words, settings_used);
    $display("results compared: %0d, bad fields: %0d", words_checked, bad_fields);
    if (bad_fields == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
